// ===== hw/rtl/gbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared types and constants for the grid binning difference block.
// ----------------------------------------------------------------------------
package gbd_pkg;

  localparam int unsigned DEF_MAX_ROWS = 128;
  localparam int unsigned DEF_MAX_COLS = 128;
  localparam int unsigned FRAC_BITS    = 16;

  localparam int unsigned VAL_W   = 32;            // coordinate and sample width
  localparam int unsigned DLT_W   = 31;            // spacing width
  localparam int unsigned LIM_W   = 8;             // row / column count width
  localparam int unsigned EPS_W   = 14;            // width of the 10000 scale
  localparam int unsigned NUM_W   = 48;            // (d * 10000 + delta), signed
  localparam int unsigned DEN_W   = DLT_W + EPS_W; // delta * 10000, unsigned
  localparam int unsigned REM_W   = NUM_W - 1;     // positive dividend
  localparam int unsigned CMP_W   = DEN_W + LIM_W; // divisor shifted by a full quotient
  localparam int unsigned DIFF_W  = VAL_W + 1;
  localparam int unsigned STEP_W  = 3;             // quotient bit counter

  localparam logic [EPS_W-1:0] EPS_SCALE = EPS_W'(10000);
  localparam logic [DLT_W-1:0] DELTA_RST = DLT_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    CFG_X_MIN     = 3'd0,
    CFG_Y_MIN     = 3'd1,
    CFG_DELTA_X   = 3'd2,
    CFG_DELTA_Y   = 3'd3,
    CFG_NUM_COLS  = 3'd4,
    CFG_NUM_ROWS  = 3'd5,
    CFG_LAT_FIRST = 3'd6
  } cfg_idx_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] x_min;
    logic [VAL_W-1:0] y_min;
    logic [DLT_W-1:0] delta_x;
    logic [DLT_W-1:0] delta_y;
    logic [LIM_W-1:0] num_cols;
    logic [LIM_W-1:0] num_rows;
    logic             lat_first;
  } cfg_t;

  // One classified item on its way from the front to the back
  typedef struct packed {
    logic             cmd;
    logic             drop;
    logic [VAL_W-1:0] lon;
    logic [VAL_W-1:0] lat;
    logic [VAL_W-1:0] sample;
    logic [NUM_W-1:0] num_x;
    logic [DEN_W-1:0] den_x;
    logic [NUM_W-1:0] num_y;
    logic [DEN_W-1:0] den_y;
    logic [LIM_W-1:0] cols_lim;
    logic [LIM_W-1:0] rows_lim;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } be_stat_t;

  typedef enum logic [2:0] {
    BE_CLR,
    BE_IDLE,
    BE_DIV,
    BE_LOOK,
    BE_DONE
  } be_state_t;

endpackage

// ===== hw/rtl/gbd_front.sv =====
// ----------------------------------------------------------------------------
// gbd_front
// Swaps coordinates, forms the scaled dividends and divisors, clamps limits.
// ----------------------------------------------------------------------------
module gbd_front #(
  parameter int unsigned MAX_ROWS = gbd_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = gbd_pkg::DEF_MAX_COLS
) (
  input  gbd_pkg::cfg_t                    cfg,
  input  logic                             cmd,
  input  logic [gbd_pkg::VAL_W-1:0]        coord_a,
  input  logic [gbd_pkg::VAL_W-1:0]        coord_b,
  input  logic [gbd_pkg::VAL_W-1:0]        sample,
  output gbd_pkg::item_t                   item
);

  localparam int unsigned LW = 13;

  logic [gbd_pkg::VAL_W-1:0] lon, lat;
  logic signed [gbd_pkg::VAL_W:0] dx, dy;
  logic [LW-1:0] rows_ext, cols_ext;

  always_comb begin
    lon = cfg.lat_first ? coord_b : coord_a;
    lat = cfg.lat_first ? coord_a : coord_b;
    dx  = $signed({lon[gbd_pkg::VAL_W-1], lon}) - $signed({cfg.x_min[gbd_pkg::VAL_W-1], cfg.x_min});
    dy  = $signed({lat[gbd_pkg::VAL_W-1], lat}) - $signed({cfg.y_min[gbd_pkg::VAL_W-1], cfg.y_min});
    rows_ext = LW'(cfg.num_rows);
    cols_ext = LW'(cfg.num_cols);

    item.cmd    = cmd;
    item.lon    = lon;
    item.lat    = lat;
    item.sample = sample;
    item.num_x  = gbd_pkg::NUM_W'($signed(gbd_pkg::NUM_W'(dx) * $signed({1'b0, gbd_pkg::EPS_SCALE})))
                + gbd_pkg::NUM_W'(cfg.delta_x);
    item.num_y  = gbd_pkg::NUM_W'($signed(gbd_pkg::NUM_W'(dy) * $signed({1'b0, gbd_pkg::EPS_SCALE})))
                + gbd_pkg::NUM_W'(cfg.delta_y);
    item.den_x  = gbd_pkg::DEN_W'(cfg.delta_x) * gbd_pkg::DEN_W'(gbd_pkg::EPS_SCALE);
    item.den_y  = gbd_pkg::DEN_W'(cfg.delta_y) * gbd_pkg::DEN_W'(gbd_pkg::EPS_SCALE);
    item.rows_lim = (rows_ext > LW'(MAX_ROWS)) ? gbd_pkg::LIM_W'(MAX_ROWS) : cfg.num_rows;
    item.cols_lim = (cols_ext > LW'(MAX_COLS)) ? gbd_pkg::LIM_W'(MAX_COLS) : cfg.num_cols;
    // zero spacing or an empty grid lands nowhere
    item.drop = (cfg.delta_x == '0) || (cfg.delta_y == '0) ||
                (cfg.num_rows == '0) || (cfg.num_cols == '0);
  end

endmodule

// ===== hw/rtl/gbd_fifo.sv =====
// ----------------------------------------------------------------------------
// gbd_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module gbd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gbd_pkg::item_t push_data,
  input  logic           pop,
  output gbd_pkg::item_t pop_data,
  output logic           full,
  output logic           empty,
  output logic [1:0]     count
);

  gbd_pkg::item_t slot_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop  ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_data;
  end

  assign pop_data = slot_r[rptr_r];
  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign count    = cnt_r;

endmodule

// ===== hw/rtl/gbd_back.sv =====
// ----------------------------------------------------------------------------
// gbd_back
// Bit-serial row and column division, grid memory, result register.
// ----------------------------------------------------------------------------
module gbd_back #(
  parameter int unsigned MAX_ROWS = gbd_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = gbd_pkg::DEF_MAX_COLS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  gbd_pkg::item_t               q_data,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [103:0]                 out_tdata,
  output gbd_pkg::be_stat_t            stat
);

  localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned MW    = gbd_pkg::VAL_W + 1;
  localparam int unsigned VW    = gbd_pkg::VAL_W;
  localparam int unsigned LW    = gbd_pkg::LIM_W;

  gbd_pkg::be_state_t state_r, state_nxt;

  gbd_pkg::item_t              it_r;
  logic [gbd_pkg::REM_W-1:0]   rem_x_r, rem_y_r;
  logic [LW-1:0]               q_x_r, q_y_r;
  logic                        rej_x_r, rej_y_r;
  logic [gbd_pkg::STEP_W-1:0]  step_r;
  logic [AW-1:0]               clr_r;
  logic [MW-1:0]               mem [CELLS];
  logic [MW-1:0]               rdata_r;
  logic                        out_valid_r;
  logic [103:0]                out_data_r;

  logic                        load_item, div_step, mem_we, mem_re, out_load, hit;
  logic [AW-1:0]               addr, waddr;
  logic [MW-1:0]               wdata;
  logic [gbd_pkg::DIFF_W-1:0]  diff;

  // one quotient bit: compare the remainder with the divisor shifted by k
  function automatic logic [gbd_pkg::REM_W:0] div_bit(
    input logic [gbd_pkg::REM_W-1:0] rem,
    input logic [gbd_pkg::DEN_W-1:0] den,
    input logic [gbd_pkg::STEP_W-1:0] k
  );
    logic [gbd_pkg::CMP_W-1:0] trial;
    logic [gbd_pkg::CMP_W-1:0] r_ext;
    logic                      ge;
    logic [gbd_pkg::REM_W-1:0] nrem;
    trial = gbd_pkg::CMP_W'(den) << k;
    r_ext = gbd_pkg::CMP_W'(rem);
    ge    = (r_ext >= trial);
    nrem  = ge ? gbd_pkg::REM_W'(r_ext - trial) : rem;
    return {ge, nrem};
  endfunction

  // reject below the grid: quotient toward zero is negative iff num <= -den
  function automatic logic below(input logic [gbd_pkg::NUM_W-1:0] num,
                                 input logic [gbd_pkg::DEN_W-1:0] den);
    logic signed [gbd_pkg::NUM_W:0] s;
    s = $signed({num[gbd_pkg::NUM_W-1], num}) + $signed((gbd_pkg::NUM_W+1)'(den));
    return (s <= 0);
  endfunction

  function automatic logic too_big(input logic [gbd_pkg::NUM_W-1:0] num,
                                   input logic [gbd_pkg::DEN_W-1:0] den);
    return (gbd_pkg::CMP_W'(num[gbd_pkg::REM_W-1:0]) >= (gbd_pkg::CMP_W'(den) << LW))
           && !num[gbd_pkg::NUM_W-1];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbd_pkg::BE_CLR:  if (clr_r == AW'(CELLS - 1)) state_nxt = gbd_pkg::BE_IDLE;
      gbd_pkg::BE_IDLE: if (!q_empty && !q_data.drop) state_nxt = gbd_pkg::BE_DIV;
      gbd_pkg::BE_DIV:  if (step_r == '0) state_nxt = gbd_pkg::BE_LOOK;
      gbd_pkg::BE_LOOK: begin
        if (hit && it_r.cmd == gbd_pkg::CMD_QUERY) state_nxt = gbd_pkg::BE_DONE;
        else                                       state_nxt = gbd_pkg::BE_IDLE;
      end
      gbd_pkg::BE_DONE: if (!rdata_r[VW] || !out_valid_r || out_tready)
                          state_nxt = gbd_pkg::BE_IDLE;
      default:          state_nxt = gbd_pkg::BE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    hit  = !rej_x_r && !rej_y_r && (q_x_r < it_r.cols_lim) && (q_y_r < it_r.rows_lim);
    addr = AW'(int'(q_y_r) * int'(MAX_COLS) + int'(q_x_r));
    diff = gbd_pkg::DIFF_W'($signed({it_r.sample[VW-1], it_r.sample})
                            - $signed({rdata_r[VW-1], rdata_r[VW-1:0]}));
    load_item = 1'b0;
    div_step  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    waddr     = addr;
    wdata     = {1'b1, it_r.sample};
    unique case (state_r)
      gbd_pkg::BE_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_r;
        wdata  = '0;
      end
      gbd_pkg::BE_IDLE: load_item = !q_empty;
      gbd_pkg::BE_DIV:  div_step  = 1'b1;
      gbd_pkg::BE_LOOK: begin
        mem_we = hit && (it_r.cmd == gbd_pkg::CMD_LOAD);
        mem_re = hit && (it_r.cmd == gbd_pkg::CMD_QUERY);
      end
      gbd_pkg::BE_DONE: out_load = rdata_r[VW] && (!out_valid_r || out_tready);
      default: ;
    endcase
  end

  assign q_pop = load_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbd_pkg::BE_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gbd_pkg::BE_CLR) clr_r <= clr_r + AW'(1);
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      it_r    <= q_data;
      rem_x_r <= q_data.num_x[gbd_pkg::NUM_W-1] ? '0 : q_data.num_x[gbd_pkg::REM_W-1:0];
      rem_y_r <= q_data.num_y[gbd_pkg::NUM_W-1] ? '0 : q_data.num_y[gbd_pkg::REM_W-1:0];
      rej_x_r <= below(q_data.num_x, q_data.den_x) || too_big(q_data.num_x, q_data.den_x);
      rej_y_r <= below(q_data.num_y, q_data.den_y) || too_big(q_data.num_y, q_data.den_y);
      q_x_r   <= '0;
      q_y_r   <= '0;
      step_r  <= gbd_pkg::STEP_W'(LW - 1);
    end else if (div_step) begin
      {q_x_r[step_r], rem_x_r} <= div_bit(rem_x_r, it_r.den_x, step_r);
      {q_y_r[step_r], rem_y_r} <= div_bit(rem_y_r, it_r.den_y, step_r);
      step_r <= step_r - gbd_pkg::STEP_W'(1);
    end
    if (out_load) out_data_r <= {7'b0, diff, it_r.lat, it_r.lon};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_r <= mem[addr];
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;
  assign stat.clearing  = (state_r == gbd_pkg::BE_CLR);
  assign stat.busy      = (state_r != gbd_pkg::BE_IDLE);

endmodule

// ===== hw/rtl/grid_bin_difference.sv =====
// ----------------------------------------------------------------------------
// grid_bin_difference
// Bins points into a regular grid; queries report sample minus stored value.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tdata {sample, coord_b, coord_a}, tuser cmd
//  out_    | master    | tdata {difference, lat_out, lon_out}
//  cfg_    | slave     | cfg_index register, cfg_data value
//
//  An item is picked from the queue, its row and column quotients are formed
//  bit by bit side by side, one memory access follows, and a query hit is
//  emitted. After reset a clearing pass runs over all MAX_ROWS*MAX_COLS grid
//  memory cells; in_tready stays low meanwhile. A stalled result holds the
//  back; the two-entry queue keeps taking input until it fills.
// ----------------------------------------------------------------------------
module grid_bin_difference #(
  parameter int unsigned MAX_ROWS = gbd_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = gbd_pkg::DEF_MAX_COLS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // coord_a [31:0], coord_b [63:32], sample [95:64]
  input  logic [0:0]   in_tuser,   // cmd [0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // lon_out [31:0], lat_out [63:32], difference [96:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  gbd_pkg::cfg_t     cfg_r;
  gbd_pkg::item_t    fe_item, q_item;
  gbd_pkg::be_stat_t be_stat;
  logic              q_full, q_empty, q_pop, push;
  logic [1:0]        q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min     <= '0;
      cfg_r.y_min     <= '0;
      cfg_r.delta_x   <= gbd_pkg::DELTA_RST;
      cfg_r.delta_y   <= gbd_pkg::DELTA_RST;
      cfg_r.num_cols  <= gbd_pkg::LIM_W'(128);
      cfg_r.num_rows  <= gbd_pkg::LIM_W'(128);
      cfg_r.lat_first <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        gbd_pkg::CFG_X_MIN:     cfg_r.x_min     <= cfg_data;
        gbd_pkg::CFG_Y_MIN:     cfg_r.y_min     <= cfg_data;
        gbd_pkg::CFG_DELTA_X:   cfg_r.delta_x   <= cfg_data[gbd_pkg::DLT_W-1:0];
        gbd_pkg::CFG_DELTA_Y:   cfg_r.delta_y   <= cfg_data[gbd_pkg::DLT_W-1:0];
        gbd_pkg::CFG_NUM_COLS:  cfg_r.num_cols  <= cfg_data[gbd_pkg::LIM_W-1:0];
        gbd_pkg::CFG_NUM_ROWS:  cfg_r.num_rows  <= cfg_data[gbd_pkg::LIM_W-1:0];
        gbd_pkg::CFG_LAT_FIRST: cfg_r.lat_first <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full && !be_stat.clearing;
  assign push      = in_tvalid && in_tready;

  gbd_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .cfg     (cfg_r),
    .cmd     (in_tuser[0]),
    .coord_a (in_tdata[31:0]),
    .coord_b (in_tdata[63:32]),
    .sample  (in_tdata[95:64]),
    .item    (fe_item)
  );

  gbd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (fe_item),
    .pop       (q_pop),
    .pop_data  (q_item),
    .full      (q_full),
    .empty     (q_empty),
    .count     (q_count)
  );

  gbd_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (be_stat)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    be_stat.clearing |-> !push) else $error("input taken during clearing pass");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count != 2'd3) else $error("queue count out of range");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    be_stat.clearing |-> !out_tvalid) else $error("result during clearing pass");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Loads grid cells and queries them through the streaming ports, predicts
// each difference beat in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;

  // Grid contents and configuration, kept in step with the block
  class grid_scoreboard;
    logic [31:0] x_min, y_min;
    logic [30:0] delta_x, delta_y;
    logic [7:0]  num_cols, num_rows;
    logic        lat_first;
    logic [31:0] cell_value [16384];
    bit          cell_valid [16384];
    logic [31:0] lon_q [$];
    logic [31:0] lat_q [$];
    logic [32:0] diff_q [$];
    int          errors;

    function new();
      x_min = '0; y_min = '0; delta_x = 31'd65536; delta_y = 31'd65536;
      num_cols = 8'd128; num_rows = 8'd128; lat_first = 1'b0;
      foreach (cell_valid[i]) cell_valid[i] = 0;
      errors = 0;
    endfunction

    function void write_reg(gbd_pkg::cfg_idx_t idx, logic [31:0] v);
      case (idx)
        gbd_pkg::CFG_X_MIN:     x_min = v;
        gbd_pkg::CFG_Y_MIN:     y_min = v;
        gbd_pkg::CFG_DELTA_X:   delta_x = v[30:0];
        gbd_pkg::CFG_DELTA_Y:   delta_y = v[30:0];
        gbd_pkg::CFG_NUM_COLS:  num_cols = v[7:0];
        gbd_pkg::CFG_NUM_ROWS:  num_rows = v[7:0];
        gbd_pkg::CFG_LAT_FIRST: lat_first = v[0];
        default: ;
      endcase
    endfunction

    // Bin index or -1 when outside
    function longint bin_of(logic [31:0] pos, logic [31:0] lo, logic [30:0] dl,
                            logic [7:0] lim);
      longint d, num, den, q, l;
      if (dl == 0) return -1;
      d = longint'($signed(pos)) - longint'($signed(lo));
      num = d * 10000 + longint'(dl);
      den = longint'(dl) * 10000;
      q = num / den;
      l = (lim > 128) ? 128 : lim;
      if (q < 0 || q >= l) return -1;
      return q;
    endfunction

    function void note_item(logic cmd, logic [31:0] a, logic [31:0] b, logic [31:0] s);
      logic [31:0] lon, lat;
      longint r, c;
      int slot;
      lon = lat_first ? b : a;
      lat = lat_first ? a : b;
      r = bin_of(lat, y_min, delta_y, num_rows);
      c = bin_of(lon, x_min, delta_x, num_cols);
      if (r < 0 || c < 0) return;
      slot = int'(r) * 128 + int'(c);
      if (cmd == gbd_pkg::CMD_LOAD) begin
        cell_value[slot] = s;
        cell_valid[slot] = 1;
      end else if (cell_valid[slot]) begin
        lon_q.push_back(lon);
        lat_q.push_back(lat);
        diff_q.push_back(33'({s[31], s}) - 33'({cell_value[slot][31], cell_value[slot]}));
      end
    endfunction

    function void check_result(logic [103:0] t);
      if (diff_q.size() == 0) begin
        $error("unexpected result beat %h", t);
        errors++;
        return;
      end
      if (t[31:0] !== lon_q[0]) begin
        $error("lon_out expected %h got %h", lon_q[0], t[31:0]); errors++;
      end
      if (t[63:32] !== lat_q[0]) begin
        $error("lat_out expected %h got %h", lat_q[0], t[63:32]); errors++;
      end
      if (t[96:64] !== diff_q[0]) begin
        $error("difference expected %h got %h", diff_q[0], t[96:64]); errors++;
      end
      void'(lon_q.pop_front()); void'(lat_q.pop_front()); void'(diff_q.pop_front());
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  grid_scoreboard sb = new();
  longint cycles = 0;
  bit     rx_stall_on = 1'b1;

  always #1 clk = ~clk;

  grid_bin_difference dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (!rx_stall_on) out_tready <= 1'b1;
    else if ($urandom_range(0, 99) < 3) out_tready <= 1'b0;
    else if ($urandom_range(0, 9) < 7) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic cmd, logic [31:0] a, logic [31:0] b, logic [31:0] s);
    int g = gap_len();
    repeat (g) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s, b, a};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(cmd, a, b, s);
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all results, then let a dropped item still in flight drain
  task automatic settle();
    end_burst();
    while (sb.diff_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(gbd_pkg::cfg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Coordinate inside or around the grid along one axis
  function automatic logic [31:0] axis_pos(logic [31:0] lo, logic [30:0] dl, logic [7:0] n);
    longint span, v;
    span = longint'(dl) * (n + 2);
    if (span == 0) span = 1;
    v = longint'($signed(lo)) - longint'(dl) + longint'($urandom_range(0, 1 << 30)) % span;
    if ($urandom_range(0, 19) == 0) return $urandom();
    if ($urandom_range(0, 9) == 0) v = longint'($signed(lo)) + longint'(dl) * $urandom_range(0, n);
    return v[31:0];
  endfunction

  task automatic random_phase(int count);
    logic [31:0] lon, lat;
    for (int i = 0; i < count; i++) begin
      lon = axis_pos(sb.x_min, sb.delta_x, (sb.num_cols > 128) ? 8'd128 : sb.num_cols);
      lat = axis_pos(sb.y_min, sb.delta_y, (sb.num_rows > 128) ? 8'd128 : sb.num_rows);
      if (sb.lat_first) send_item($urandom_range(0, 2) != 0, lat, lon, $urandom());
      else send_item($urandom_range(0, 2) != 0, lon, lat, $urandom());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cell, extremes, below-minimum bin, outside grid
    send_item(gbd_pkg::CMD_QUERY, 32'h0001_8000, 32'h0002_0000, 32'h1);
    send_item(gbd_pkg::CMD_LOAD,  32'h0001_8000, 32'h0002_0000, 32'h8000_0000);
    send_item(gbd_pkg::CMD_QUERY, 32'h0001_0000, 32'h0002_4000, 32'h7FFF_FFFF);
    send_item(gbd_pkg::CMD_LOAD,  32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF);
    send_item(gbd_pkg::CMD_QUERY, 32'h0001_0000, 32'h0002_0000, 32'h8000_0000);
    send_item(gbd_pkg::CMD_LOAD,  32'hFFFF_8000, 32'hFFFF_0001, 32'hFFFF_FFFF);
    send_item(gbd_pkg::CMD_QUERY, 32'h0000_0000, 32'h0000_0000, 32'h0);
    send_item(gbd_pkg::CMD_LOAD,  32'h007F_FFFF, 32'h007F_FFFF, 32'h1234_5678);
    send_item(gbd_pkg::CMD_QUERY, 32'h007F_0000, 32'h007F_8000, 32'h0);
    send_item(gbd_pkg::CMD_LOAD,  32'h0080_0000, 32'h0000_0000, 32'h5);
    send_item(gbd_pkg::CMD_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5);
    send_item(gbd_pkg::CMD_QUERY, 32'hFFFE_0000, 32'h0000_0000, 32'h5);
    send_item(gbd_pkg::CMD_LOAD,  32'h0003_0000, 32'h0004_0000, 32'h10);
    send_item(gbd_pkg::CMD_LOAD,  32'h0003_0000, 32'h0004_0000, 32'h20);
    send_item(gbd_pkg::CMD_QUERY, 32'h0003_FFFF, 32'h0004_FFFF, 32'h7);
    settle();
    random_phase(250);
    settle();

    // Swapped order, offset grid, small cells
    write_cfg(gbd_pkg::CFG_X_MIN, 32'hFFF0_0000);
    write_cfg(gbd_pkg::CFG_Y_MIN, 32'h0010_0000);
    write_cfg(gbd_pkg::CFG_DELTA_X, 32'h0000_4000);
    write_cfg(gbd_pkg::CFG_DELTA_Y, 32'h0002_0000);
    write_cfg(gbd_pkg::CFG_NUM_COLS, 32'd10);
    write_cfg(gbd_pkg::CFG_NUM_ROWS, 32'd7);
    write_cfg(gbd_pkg::CFG_LAT_FIRST, 32'd1);
    random_phase(300);
    settle();

    // Extremes: one column by two rows, huge spacing, most negative bounds
    write_cfg(gbd_pkg::CFG_X_MIN, 32'h8000_0000);
    write_cfg(gbd_pkg::CFG_Y_MIN, 32'h8000_0000);
    write_cfg(gbd_pkg::CFG_DELTA_X, 32'h7FFF_FFFF);
    write_cfg(gbd_pkg::CFG_DELTA_Y, 32'h7FFF_FFFF);
    write_cfg(gbd_pkg::CFG_NUM_COLS, 32'd1);
    write_cfg(gbd_pkg::CFG_NUM_ROWS, 32'd2);
    write_cfg(gbd_pkg::CFG_LAT_FIRST, 32'd0);
    random_phase(150);
    settle();

    // Oversized grid counts, tiny spacing
    write_cfg(gbd_pkg::CFG_X_MIN, 32'h7FFF_FF00);
    write_cfg(gbd_pkg::CFG_Y_MIN, 32'h0);
    write_cfg(gbd_pkg::CFG_DELTA_X, 32'h1);
    write_cfg(gbd_pkg::CFG_DELTA_Y, 32'h3);
    write_cfg(gbd_pkg::CFG_NUM_COLS, 32'd255);
    write_cfg(gbd_pkg::CFG_NUM_ROWS, 32'd200);
    random_phase(200);
    settle();

    // Zero spacing and zero counts drop everything
    write_cfg(gbd_pkg::CFG_DELTA_X, 32'h0);
    random_phase(40);
    settle();
    write_cfg(gbd_pkg::CFG_DELTA_X, 32'h0001_0000);
    write_cfg(gbd_pkg::CFG_NUM_ROWS, 32'd0);
    random_phase(40);
    settle();

    // Dense reuse of a small grid, no receiver stalls for part of it
    write_cfg(gbd_pkg::CFG_X_MIN, 32'h0);
    write_cfg(gbd_pkg::CFG_DELTA_Y, 32'h0001_0000);
    write_cfg(gbd_pkg::CFG_NUM_COLS, 32'd4);
    write_cfg(gbd_pkg::CFG_NUM_ROWS, 32'd4);
    write_cfg(gbd_pkg::CFG_LAT_FIRST, 32'd1);
    rx_stall_on = 1'b0;
    random_phase(250);
    rx_stall_on = 1'b1;
    random_phase(300);
    settle();

    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
